FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy allocator package
// Sizes, codes, item types and tree helper functions.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAX_ARENA_ORDER   = 16;
    localparam int MIN_BLOCK_ORDER   = 5;
    localparam int HEADER_BYTES      = 8;
    localparam int MIN_REQUEST_BYTES = 16;

    localparam int TREE_LEVELS = MAX_ARENA_ORDER - MIN_BLOCK_ORDER + 1;
    localparam int NODE_AW     = TREE_LEVELS;
    localparam int NODE_DEPTH  = 1 << NODE_AW;
    localparam int SLOT_AW     = MAX_ARENA_ORDER - MIN_BLOCK_ORDER;
    localparam int SLOT_DEPTH  = 1 << SLOT_AW;
    localparam int MASK_W      = TREE_LEVELS;
    localparam int ORDER_W     = 5;
    localparam int ADDR_W      = 16;
    localparam int SIZE_W      = 16;
    localparam int NEED_W      = SIZE_W + 1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_MEM    = 2'd1;
    localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;
    localparam logic [1:0] STATUS_BAD_FREE  = 2'd3;

    typedef logic [MASK_W-1:0]  mask_t;
    typedef logic [NODE_AW-1:0] node_t;
    typedef logic [SLOT_AW-1:0] slot_t;
    typedef logic [ORDER_W-1:0] order_t;
    typedef logic [ADDR_W-1:0]  addr_t;

    typedef struct packed {
        logic              opcode;
        logic [SIZE_W-1:0] request_size;
        addr_t             user_address;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        addr_t      granted_address;
        order_t     block_order;
    } resp_t;

    // Tree store port: one write and one read per cycle.
    typedef struct packed {
        logic  we;
        node_t waddr;
        mask_t wdata;
        node_t raddr;
    } tree_port_t;

    typedef struct packed {
        logic   we;
        slot_t  waddr;
        order_t wdata;
        slot_t  raddr;
    } slot_port_t;

    function automatic mask_t order_bit(order_t o);
        return mask_t'(1) << (o - order_t'(MIN_BLOCK_ORDER));
    endfunction

    // Bits for orders lo .. hi-1.
    function automatic mask_t order_span(order_t lo, order_t hi);
        logic [MASK_W:0] a;
        logic [MASK_W:0] b;
        a = (MASK_W+1)'(1) << (hi - order_t'(MIN_BLOCK_ORDER));
        b = (MASK_W+1)'(1) << (lo - order_t'(MIN_BLOCK_ORDER));
        return mask_t'(a - b);
    endfunction

    function automatic order_t request_order(logic [SIZE_W-1:0] size);
        logic [NEED_W-1:0] need;
        logic [NEED_W-1:0] v;
        order_t            k;
        need = (size < SIZE_W'(MIN_REQUEST_BYTES)) ? NEED_W'(MIN_REQUEST_BYTES)
                                                   : {1'b0, size};
        need = need + NEED_W'(HEADER_BYTES);
        v    = need - NEED_W'(1);
        k    = order_t'(MIN_BLOCK_ORDER);
        for (int i = 0; i < NEED_W; i++) begin
            if (v[i] && (i + 1) > MIN_BLOCK_ORDER) begin
                k = order_t'(i + 1);
            end
        end
        return k;
    endfunction

    function automatic order_t lowest_order(mask_t m);
        order_t o;
        o = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                o = order_t'(i + MIN_BLOCK_ORDER);
            end
        end
        return o;
    endfunction

    function automatic order_t bound_order(logic [ORDER_W-1:0] v);
        order_t o;
        if (v < order_t'(MIN_BLOCK_ORDER)) begin
            o = order_t'(MIN_BLOCK_ORDER);
        end else if (v > order_t'(MAX_ARENA_ORDER)) begin
            o = order_t'(MAX_ARENA_ORDER);
        end else begin
            o = v;
        end
        return o;
    endfunction

    // Heap numbering: level L starts at 2^L - 1, children at 2n+1 and 2n+2.
    function automatic node_t node_index(order_t o, addr_t off);
        logic [NODE_AW:0] base;
        addr_t            q;
        base = (NODE_AW+1)'(1) << (order_t'(MAX_ARENA_ORDER) - o);
        q    = off >> o;
        return node_t'(base - (NODE_AW+1)'(1) + (NODE_AW+1)'(q));
    endfunction

    function automatic node_t left_child(node_t n);
        return node_t'({n, 1'b0} + (NODE_AW+1)'(1));
    endfunction

    function automatic node_t parent_of(node_t n);
        return node_t'((n - node_t'(1)) >> 1);
    endfunction

    function automatic node_t sibling_of(node_t n);
        return n[0] ? (n + node_t'(1)) : (n - node_t'(1));
    endfunction

    function automatic slot_t slot_of(addr_t off);
        return off[MIN_BLOCK_ORDER +: SLOT_AW];
    endfunction

endpackage

FILE: hw/rtl/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Allocates and frees power-of-two blocks of a 2^arena_order byte arena.
// ----------------------------------------------------------------------------
// Usage:
//   s_ takes one request item (allocate or free); m_ returns one result item
//   per request, in order. Both use valid/ready. cfg_wr_en/cfg_wr_data write
//   arena_order (saturated to 5..16); each write resets the arena to one free block.
//   State: a per-node mask of free orders in the subtree (4096 x 12 RAM) and a
//   granted-order table per 32-byte slot (2048 x 5 RAM).
//   An allocate reads down from the root one level at a time to the smallest
//   free order that fits, splits that block down to the requested order k and
//   rewrites the masks back up to the root; a free merges with free buddies on
//   the way up. Errors (too large, malformed address, no memory, address not
//   granted) skip the tree updates.
//   One item is in work at a time; the next is taken from the cycle after the
//   result is loaded, so it may start while a result waits.
//   After reset and after every configuration write a clearing pass over all
//   4096 tree nodes runs with s_ready low.
//   When m_ready is low the result is held; a finished item then waits in
//   the engine and s_ready stays low until the output register frees.
// ----------------------------------------------------------------------------
module buddy_block_allocator (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [4:0]      cfg_wr_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  bba_pkg::req_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output bba_pkg::resp_t  m_data
);

    bba_pkg::order_t     arena_reg, arena_next;
    logic                clear_busy_reg, clear_busy_next;
    bba_pkg::node_t      clear_cnt_reg, clear_cnt_next;

    logic                eng_idle;
    logic                in_fire;
    bba_pkg::tree_port_t eng_tree;
    bba_pkg::slot_port_t eng_slot;
    bba_pkg::tree_port_t tree_port;
    bba_pkg::slot_port_t slot_port;
    bba_pkg::mask_t      tree_rdata;
    bba_pkg::order_t     slot_rdata;

    always_comb begin
        arena_next      = arena_reg;
        clear_busy_next = clear_busy_reg;
        clear_cnt_next  = clear_cnt_reg;
        if (cfg_wr_en) begin
            arena_next      = bba_pkg::bound_order(cfg_wr_data);
            clear_busy_next = 1'b1;
            clear_cnt_next  = '0;
        end else if (clear_busy_reg) begin
            clear_cnt_next = clear_cnt_reg + bba_pkg::node_t'(1);
            if (clear_cnt_reg == bba_pkg::node_t'(bba_pkg::NODE_DEPTH - 1)) begin
                clear_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arena_reg      <= bba_pkg::order_t'(bba_pkg::MAX_ARENA_ORDER);
            clear_busy_reg <= 1'b1;
            clear_cnt_reg  <= '0;
        end else begin
            arena_reg      <= arena_next;
            clear_busy_reg <= clear_busy_next;
            clear_cnt_reg  <= clear_cnt_next;
        end
    end

    assign s_ready = eng_idle && !clear_busy_reg;
    assign in_fire = s_valid && s_ready;

    // Sweep both stores while clearing; only the arena root starts free.
    always_comb begin
        if (clear_busy_reg) begin
            tree_port.we    = 1'b1;
            tree_port.waddr = clear_cnt_reg;
            tree_port.wdata = (clear_cnt_reg == bba_pkg::node_index(arena_reg, '0))
                              ? bba_pkg::order_bit(arena_reg) : '0;
            tree_port.raddr = eng_tree.raddr;
            slot_port.we    = 1'b1;
            slot_port.waddr = clear_cnt_reg[bba_pkg::SLOT_AW-1:0];
            slot_port.wdata = '0;
            slot_port.raddr = eng_slot.raddr;
        end else begin
            tree_port = eng_tree;
            slot_port = eng_slot;
        end
    end

    bba_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .arena_order (arena_reg),
        .in_fire     (in_fire),
        .in_item     (s_data),
        .idle        (eng_idle),
        .tree_port   (eng_tree),
        .tree_rdata  (tree_rdata),
        .slot_port   (eng_slot),
        .slot_rdata  (slot_rdata),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    bba_ram #(
        .WIDTH (bba_pkg::MASK_W),
        .DEPTH (bba_pkg::NODE_DEPTH)
    ) u_tree_ram (
        .aclk  (aclk),
        .we    (tree_port.we),
        .waddr (tree_port.waddr),
        .wdata (tree_port.wdata),
        .raddr (tree_port.raddr),
        .rdata (tree_rdata)
    );

    bba_ram #(
        .WIDTH (bba_pkg::ORDER_W),
        .DEPTH (bba_pkg::SLOT_DEPTH)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_port.we),
        .waddr (slot_port.waddr),
        .wdata (slot_port.wdata),
        .raddr (slot_port.raddr),
        .rdata (slot_rdata)
    );

endmodule

FILE: hw/rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/bba_engine.sv
// ----------------------------------------------------------------------------
// Buddy allocator engine
// Walks the free-order tree one level per step, splits and merges blocks and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module bba_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  bba_pkg::order_t     arena_order,
    input  logic                in_fire,
    input  bba_pkg::req_t       in_item,
    output logic                idle,
    output bba_pkg::tree_port_t tree_port,
    input  bba_pkg::mask_t      tree_rdata,
    output bba_pkg::slot_port_t slot_port,
    input  bba_pkg::order_t     slot_rdata,
    output logic                m_valid,
    input  logic                m_ready,
    output bba_pkg::resp_t      m_data
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ROOT      = 4'd1;
    localparam logic [3:0] S_DESC      = 4'd2;
    localparam logic [3:0] S_FOUND     = 4'd3;
    localparam logic [3:0] S_SPLIT_L   = 4'd4;
    localparam logic [3:0] S_SPLIT_R   = 4'd5;
    localparam logic [3:0] S_UP_WR     = 4'd6;
    localparam logic [3:0] S_UP_RD     = 4'd7;
    localparam logic [3:0] S_FREE      = 4'd8;
    localparam logic [3:0] S_MERGE     = 4'd9;
    localparam logic [3:0] S_MERGE_CLR = 4'd10;
    localparam logic [3:0] S_DONE      = 4'd11;

    logic [3:0]      state_reg, state_next;
    bba_pkg::node_t  node_reg, node_next;
    bba_pkg::node_t  split_node_reg, split_node_next;
    bba_pkg::order_t split_ord_reg, split_ord_next;
    bba_pkg::addr_t  off_reg, off_next;
    bba_pkg::order_t ord_reg, ord_next;
    bba_pkg::order_t k_reg, k_next;
    bba_pkg::order_t tgt_reg, tgt_next;
    bba_pkg::mask_t  cm_reg, cm_next;
    bba_pkg::resp_t  res_reg, res_next;
    bba_pkg::resp_t  out_reg;
    logic            out_valid_reg, out_valid_next;
    logic            load;

    bba_pkg::order_t ka;
    bba_pkg::addr_t  fo;
    logic            free_bad;
    logic [bba_pkg::ADDR_W:0] fo_hi;
    bba_pkg::mask_t  avail;
    bba_pkg::order_t ord_dec;
    bba_pkg::order_t ord_inc;
    bba_pkg::order_t split_dec;
    bba_pkg::node_t  desc_child;
    bba_pkg::node_t  free_node;
    bba_pkg::node_t  up_node;

    assign ka        = bba_pkg::request_order(in_item.request_size);
    assign fo        = in_item.user_address - bba_pkg::addr_t'(bba_pkg::HEADER_BYTES);
    assign fo_hi     = {1'b0, fo} >> arena_order;
    assign free_bad  = (in_item.user_address < bba_pkg::addr_t'(bba_pkg::HEADER_BYTES))
                       || (fo[bba_pkg::MIN_BLOCK_ORDER-1:0] != '0)
                       || (fo_hi != '0);
    assign avail     = tree_rdata & ~(bba_pkg::order_bit(k_reg) - bba_pkg::mask_t'(1));
    assign ord_dec   = ord_reg - bba_pkg::order_t'(1);
    assign ord_inc   = ord_reg + bba_pkg::order_t'(1);
    assign split_dec = split_ord_reg - bba_pkg::order_t'(1);
    assign desc_child = ((tree_rdata & bba_pkg::order_bit(tgt_reg)) != '0)
                        ? bba_pkg::left_child(node_reg)
                        : bba_pkg::left_child(node_reg) + bba_pkg::node_t'(1);
    assign free_node = bba_pkg::node_index(slot_rdata, off_reg);
    assign up_node   = bba_pkg::parent_of(node_reg);

    always_comb begin
        state_next      = state_reg;
        node_next       = node_reg;
        split_node_next = split_node_reg;
        split_ord_next  = split_ord_reg;
        off_next        = off_reg;
        ord_next        = ord_reg;
        k_next          = k_reg;
        tgt_next        = tgt_reg;
        cm_next         = cm_reg;
        res_next        = res_reg;
        tree_port       = '0;
        slot_port       = '0;
        load            = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    res_next.status          = bba_pkg::STATUS_OK;
                    res_next.granted_address = '0;
                    res_next.block_order     = '0;
                    if (in_item.opcode == bba_pkg::OP_ALLOC) begin
                        if (ka > arena_order) begin
                            res_next.status = bba_pkg::STATUS_TOO_LARGE;
                            state_next      = S_DONE;
                        end else begin
                            k_next          = ka;
                            node_next       = bba_pkg::node_index(arena_order, '0);
                            ord_next        = arena_order;
                            off_next        = '0;
                            tree_port.raddr = bba_pkg::node_index(arena_order, '0);
                            state_next      = S_ROOT;
                        end
                    end else begin
                        if (free_bad) begin
                            res_next.status = bba_pkg::STATUS_BAD_FREE;
                            state_next      = S_DONE;
                        end else begin
                            off_next        = fo;
                            slot_port.raddr = bba_pkg::slot_of(fo);
                            state_next      = S_FREE;
                        end
                    end
                end
            end
            S_ROOT: begin
                if (avail == '0) begin
                    res_next.status = bba_pkg::STATUS_NO_MEM;
                    state_next      = S_DONE;
                end else begin
                    tgt_next = bba_pkg::lowest_order(avail);
                    if (bba_pkg::lowest_order(avail) == ord_reg) begin
                        state_next = S_FOUND;
                    end else begin
                        tree_port.raddr = bba_pkg::left_child(node_reg);
                        state_next      = S_DESC;
                    end
                end
            end
            S_DESC: begin
                // the target order lies in the left child unless its mask lacks it
                node_next = desc_child;
                ord_next  = ord_dec;
                if ((tree_rdata & bba_pkg::order_bit(tgt_reg)) == '0) begin
                    off_next = off_reg | (bba_pkg::addr_t'(1) << ord_dec);
                end
                if (ord_dec == tgt_reg) begin
                    state_next = S_FOUND;
                end else begin
                    tree_port.raddr = bba_pkg::left_child(desc_child);
                end
            end
            S_FOUND: begin
                slot_port.we             = 1'b1;
                slot_port.waddr          = bba_pkg::slot_of(off_reg);
                slot_port.wdata          = k_reg;
                res_next.granted_address = off_reg + bba_pkg::addr_t'(bba_pkg::HEADER_BYTES);
                res_next.block_order     = k_reg;
                cm_next                  = bba_pkg::order_span(k_reg, ord_reg);
                split_node_next          = node_reg;
                split_ord_next           = ord_reg;
                state_next               = (ord_reg == k_reg) ? S_UP_WR : S_SPLIT_L;
            end
            S_SPLIT_L: begin
                tree_port.we    = 1'b1;
                tree_port.waddr = bba_pkg::left_child(split_node_reg);
                tree_port.wdata = bba_pkg::order_span(k_reg, split_dec);
                state_next      = S_SPLIT_R;
            end
            S_SPLIT_R: begin
                // upper half becomes a free block of one order less
                tree_port.we    = 1'b1;
                tree_port.waddr = bba_pkg::left_child(split_node_reg) + bba_pkg::node_t'(1);
                tree_port.wdata = bba_pkg::order_bit(split_dec);
                split_node_next = bba_pkg::left_child(split_node_reg);
                split_ord_next  = split_dec;
                state_next      = (split_dec == k_reg) ? S_UP_WR : S_SPLIT_L;
            end
            S_UP_WR: begin
                tree_port.we    = 1'b1;
                tree_port.waddr = node_reg;
                tree_port.wdata = cm_reg;
                if (ord_reg == arena_order) begin
                    state_next = S_DONE;
                end else begin
                    tree_port.raddr = bba_pkg::sibling_of(node_reg);
                    state_next      = S_UP_RD;
                end
            end
            S_UP_RD: begin
                cm_next    = cm_reg | tree_rdata;
                node_next  = up_node;
                ord_next   = ord_inc;
                state_next = S_UP_WR;
            end
            S_FREE: begin
                if (slot_rdata == '0) begin
                    res_next.status = bba_pkg::STATUS_BAD_FREE;
                    state_next      = S_DONE;
                end else begin
                    slot_port.we         = 1'b1;
                    slot_port.waddr      = bba_pkg::slot_of(off_reg);
                    slot_port.wdata      = '0;
                    res_next.block_order = slot_rdata;
                    node_next            = free_node;
                    ord_next             = slot_rdata;
                    if (slot_rdata == arena_order) begin
                        cm_next    = bba_pkg::order_bit(slot_rdata);
                        state_next = S_UP_WR;
                    end else begin
                        tree_port.raddr = bba_pkg::sibling_of(free_node);
                        state_next      = S_MERGE;
                    end
                end
            end
            S_MERGE: begin
                if ((tree_rdata & bba_pkg::order_bit(ord_reg)) != '0) begin
                    tree_port.we    = 1'b1;
                    tree_port.waddr = bba_pkg::sibling_of(node_reg);
                    tree_port.wdata = '0;
                    state_next      = S_MERGE_CLR;
                end else begin
                    cm_next    = bba_pkg::order_bit(ord_reg);
                    state_next = S_UP_WR;
                end
            end
            S_MERGE_CLR: begin
                tree_port.we    = 1'b1;
                tree_port.waddr = node_reg;
                tree_port.wdata = '0;
                node_next       = up_node;
                ord_next        = ord_inc;
                if (ord_inc == arena_order) begin
                    cm_next    = bba_pkg::order_bit(ord_inc);
                    state_next = S_UP_WR;
                end else begin
                    tree_port.raddr = bba_pkg::sibling_of(up_node);
                    state_next      = S_MERGE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!out_valid_reg || m_ready) begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg       <= node_next;
        split_node_reg <= split_node_next;
        split_ord_reg  <= split_ord_next;
        off_reg        <= off_next;
        ord_reg        <= ord_next;
        k_reg          <= k_next;
        tgt_reg        <= tgt_next;
        cm_reg         <= cm_next;
        res_reg        <= res_next;
        if (load) begin
            out_reg <= res_reg;
        end
    end

    assign idle    = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: hw/rtl/bba_checker.sv
// ----------------------------------------------------------------------------
// Buddy allocator port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           cfg_wr_en,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input bba_pkg::resp_t m_data
);

    `BBA_ASSERT_NXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    `BBA_ASSERT_IMP(a_err_zero, aclk, aresetn, m_valid && m_data.status != bba_pkg::STATUS_OK, m_data.granted_address == '0 && m_data.block_order == '0)

    `BBA_ASSERT_IMP(a_grant_shape, aclk, aresetn, m_valid && m_data.granted_address != '0, m_data.granted_address[4:0] == 5'd8 && m_data.block_order >= 5'd5 && m_data.block_order <= 5'd16)

    `BBA_ASSERT_NXT(a_cfg_clear, aclk, aresetn, cfg_wr_en, !s_ready)

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_wr_en (cfg_wr_en),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);
